[rtl/ffud_pkg.sv]
// Shared types and constants for the flag frame unescape deframer.
package ffud_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 11;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = LEN_W;
    localparam int FRAME_MAX_DEF = 1024;

    localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY    = 3'd4;

    localparam logic [BYTE_W-1:0] FLAG_BYTE_RST   = 8'h7e;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'h7d;
    localparam logic [BYTE_W-1:0] FLAG_CODE_RST   = 8'h02;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'h01;
    localparam logic [LEN_W-1:0]  MAX_BODY_RST    = 11'd1022;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              chunk_end;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
    } ev_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] flag_code;
        logic [BYTE_W-1:0] escape_code;
        logic [LEN_W-1:0]  max_body_len;
    } cfg_t;

endpackage

[rtl/ffud_cfg.sv]
// Configuration register bank for the deframer.
module ffud_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ffud_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffud_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ffud_pkg::cfg_t                   cfg
);
    import ffud_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FLAG_BYTE:   cfg_next.flag_byte    = cfg_data[BYTE_W-1:0];
                REG_ESCAPE_BYTE: cfg_next.escape_byte  = cfg_data[BYTE_W-1:0];
                REG_FLAG_CODE:   cfg_next.flag_code    = cfg_data[BYTE_W-1:0];
                REG_ESCAPE_CODE: cfg_next.escape_code  = cfg_data[BYTE_W-1:0];
                REG_MAX_BODY:    cfg_next.max_body_len = cfg_data[LEN_W-1:0];
                default:         cfg_next = cfg_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte    <= FLAG_BYTE_RST;
            cfg_reg.escape_byte  <= ESCAPE_BYTE_RST;
            cfg_reg.flag_code    <= FLAG_CODE_RST;
            cfg_reg.escape_code  <= ESCAPE_CODE_RST;
            cfg_reg.max_body_len <= MAX_BODY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/flag_frame_unescape_deframer_unit.sv]
// Top level of the flag-delimited frame deframer with byte unescaping.
//
// Raw link bytes enter one transaction per unstalled cycle on rx; each byte
// is handled in the cycle it is accepted by a small single-pass decoder
// (hunting, escape-pending and body-count state) and at most one event is
// written to the ev output register: an unescaped body byte, a clean frame
// end or an abort. Throughput is one byte per unstalled clock; ev_valid
// rises in the next cycle. rx_stall is raised only while the output register
// holds an event that the ev side is stalling. Configuration writes apply
// from the next cycle and should only be made while the block is idle.
module flag_frame_unescape_deframer_unit #(
    parameter int FRAME_MAX = ffud_pkg::FRAME_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  ffud_pkg::rx_item_t               rx_item,
    output logic                             ev_valid,
    input  logic                             ev_stall,
    output ffud_pkg::ev_item_t               ev_item,
    input  logic                             cfg_write,
    input  logic [ffud_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffud_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ffud_pkg::*;

    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CMP_W-1:0] FRAME_MAX_C = CMP_W'(FRAME_MAX);

    cfg_t cfg;

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ev_valid_reg, ev_valid_next;
    ev_item_t         ev_item_reg, ev_item_next;

    logic             accept;
    logic             have;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] limit;
    logic             room;

    ffud_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign rx_stall = ev_valid_reg && ev_stall;
    assign accept   = rx_valid && !rx_stall;

    // body limit clamped to 1..FRAME_MAX
    assign len_ext = CMP_W'(cfg.max_body_len);
    always_comb
    begin
        priority if (cfg.max_body_len == '0)
            limit = CMP_W'(1);
        else if (len_ext > FRAME_MAX_C)
            limit = FRAME_MAX_C;
        else
            limit = len_ext;
    end
    assign room = CMP_W'(count_reg) < limit;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        have          = 1'b0;
        kind          = KIND_BODY;
        data          = '0;

        priority if (!in_frame_reg)
        begin
            if (rx_item.in_byte == cfg.flag_byte)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = '0;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            have     = 1'b1;
            priority if (rx_item.in_byte == cfg.flag_code)
                data = cfg.flag_byte;
            else if (rx_item.in_byte == cfg.escape_code)
                data = cfg.escape_byte;
            else
                kind = KIND_ABORT;
        end
        else if (rx_item.in_byte == cfg.flag_byte)
        begin
            // flag on an empty frame just reopens it
            if (count_reg != '0)
            begin
                have          = 1'b1;
                kind          = KIND_END;
                in_frame_next = 1'b0;
                count_next    = '0;
            end
        end
        else if (rx_item.in_byte == cfg.escape_byte)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            have = 1'b1;
            data = rx_item.in_byte;
        end

        if (have && kind == KIND_BODY)
        begin
            if (room)
                count_next = count_reg + CNT_W'(1);
            else
                kind = KIND_ABORT;
        end

        if (have && kind == KIND_ABORT)
        begin
            data          = '0;
            in_frame_next = 1'b0;
            esc_next      = 1'b0;
            count_next    = '0;
        end

        // chunk end drops any frame still open, including one just opened
        if (rx_item.chunk_end && in_frame_next)
        begin
            have          = 1'b1;
            kind          = KIND_ABORT;
            data          = '0;
            in_frame_next = 1'b0;
            esc_next      = 1'b0;
            count_next    = '0;
        end
    end

    always_comb
    begin
        ev_valid_next = ev_valid_reg && ev_stall;
        ev_item_next  = ev_item_reg;
        if (accept && have)
        begin
            ev_valid_next         = 1'b1;
            ev_item_next.out_byte = data;
            ev_item_next.kind     = kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_frame_reg <= in_frame_next;
                esc_reg      <= esc_next;
                count_reg    <= count_next;
            end
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_item_reg <= ev_item_next;
    end

    assign ev_valid = ev_valid_reg;
    assign ev_item  = ev_item_reg;

endmodule
